// ===== design/rc4_key_schedule_assert.svh =====
// Assertion macros shared by the RC4 key schedule RTL.
`ifndef RC4_KEY_SCHEDULE_ASSERT_SVH
`define RC4_KEY_SCHEDULE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RC4KS_ASSERT_NOW(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rc4_key_schedule: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RC4KS_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rc4_key_schedule: next-cycle check failed");

`endif

// ===== design/rc4ks_pkg.sv =====
package rc4ks_pkg;

	// Size of the permutation and of its output framing.
	localparam int unsigned PERM_SIZE  = 256;
	localparam int unsigned WORD_COUNT = 64;

	// One key byte transaction.
	typedef struct packed {
		logic [7:0] key_byte;
		logic       key_last;
	} key_in_t;

	// One permutation word transaction.
	typedef struct packed {
		logic [31:0] sbox_word;
		logic [5:0]  word_index;
		logic        last_word;
		logic        key_overflow;
	} sbox_out_t;

endpackage

// ===== design/rc4_key_schedule.sv =====
// RC4 key schedule. Key bytes are taken one per cycle on the key channel, the
// byte flagged key_last closing the key; bytes beyond MAX_KEY_BYTES are dropped
// and reported through key_overflow on every output word. After the last byte
// the block stalls its input while it fills the 256-entry permutation with the
// identity, runs the 256 mixing steps, each as a read of entry i, a read of
// entry j, a write of entry i and a write of entry j, and sends the permutation
// as 64 words of four bytes, lowest entry in bits 7:0, reading the bytes one at
// a time and holding each word while the output is stalled. This sequencing comes
// from the permutation memory having a single read port and a single write port,
// so each swap needs two reads and two writes in sequence.
`include "rc4_key_schedule_assert.svh"

module rc4_key_schedule
	import rc4ks_pkg::*;
#(
	parameter int unsigned MAX_KEY_BYTES = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      key_valid,
	output logic      key_stall,
	input  key_in_t   key_data,
	output logic      sbox_valid,
	input  logic      sbox_stall,
	output sbox_out_t sbox_data
);

	localparam int unsigned KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int unsigned CW  = $clog2(MAX_KEY_BYTES + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_RD_I,
		ST_RD_J,
		ST_WR_I,
		ST_WR_J,
		ST_EMIT_RD,
		ST_EMIT_CAP,
		ST_OUT
	} state_t;

	state_t          state_q;
	logic [7:0]      idx_q;
	logic [7:0]      j_q;
	logic [KAW-1:0]  k_q;
	logic [7:0]      si_q;
	logic [31:0]     word_q;
	logic [CW-1:0]   count_q;
	logic            ovf_q;
	logic            out_valid_q;
	sbox_out_t       out_q;

	logic            perm_we;
	logic [7:0]      perm_waddr;
	logic [7:0]      perm_wdata;
	logic            perm_re;
	logic [7:0]      perm_raddr;
	logic [7:0]      perm_rdata;
	logic            key_we;
	logic [KAW-1:0]  key_waddr;
	logic            key_re;
	logic [7:0]      key_rdata;
	logic [7:0]      j_sum;
	logic            key_room;
	logic            key_accept;
	logic            k_wrap;

	// Handshake and key intake conditions.
	assign key_stall  = (state_q != ST_IDLE);
	assign key_accept = key_valid && !key_stall;
	assign key_room   = (count_q < CW'(MAX_KEY_BYTES));
	assign k_wrap     = (k_q == KAW'(count_q - CW'(1)));
	assign key_waddr  = count_q[KAW-1:0];

	// New j from the entry at i and the key byte at i mod length.
	assign j_sum = j_q + perm_rdata + key_rdata;

	// Memory port control for each phase of the schedule.
	always_comb begin
		perm_we    = 1'b0;
		perm_waddr = idx_q;
		perm_wdata = idx_q;
		perm_re    = 1'b0;
		perm_raddr = idx_q;
		key_we     = 1'b0;
		key_re     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				key_we = key_accept && key_room;
			end
			ST_FILL: begin
				perm_we = 1'b1;
			end
			ST_RD_I: begin
				perm_re = 1'b1;
				key_re  = 1'b1;
			end
			ST_RD_J: begin
				perm_re    = 1'b1;
				perm_raddr = j_sum;
			end
			ST_WR_I: begin
				perm_we    = 1'b1;
				perm_wdata = perm_rdata;
			end
			ST_WR_J: begin
				perm_we    = 1'b1;
				perm_waddr = j_q;
				perm_wdata = si_q;
			end
			ST_EMIT_RD: begin
				perm_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	rc4ks_ram #(
		.WIDTH (8),
		.DEPTH (PERM_SIZE)
	) u_perm_ram (
		.clk   (clk),
		.we    (perm_we),
		.waddr (perm_waddr),
		.wdata (perm_wdata),
		.re    (perm_re),
		.raddr (perm_raddr),
		.rdata (perm_rdata)
	);

	rc4ks_ram #(
		.WIDTH (8),
		.DEPTH (MAX_KEY_BYTES)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_data.key_byte),
		.re    (key_re),
		.raddr (k_q),
		.rdata (key_rdata)
	);

	// Sequencer: intake, identity fill, mixing swaps and word output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			j_q         <= '0;
			k_q         <= '0;
			si_q        <= '0;
			word_q      <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (key_accept) begin
						if (key_room) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (key_data.key_last) begin
							idx_q   <= '0;
							state_q <= ST_FILL;
						end
					end
				end
				ST_FILL: begin
					idx_q <= idx_q + 8'd1;
					if (idx_q == 8'hFF) begin
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_RD_I;
					end
				end
				ST_RD_I: begin
					state_q <= ST_RD_J;
				end
				ST_RD_J: begin
					si_q    <= perm_rdata;
					j_q     <= j_sum;
					state_q <= ST_WR_I;
				end
				ST_WR_I: begin
					state_q <= ST_WR_J;
				end
				ST_WR_J: begin
					idx_q <= idx_q + 8'd1;
					k_q   <= k_wrap ? '0 : k_q + KAW'(1);
					if (idx_q == 8'hFF) begin
						state_q <= ST_EMIT_RD;
					end else begin
						state_q <= ST_RD_I;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_CAP;
				end
				ST_EMIT_CAP: begin
					word_q[{idx_q[1:0], 3'b000} +: 8] <= perm_rdata;
					if (idx_q[1:0] == 2'd3) begin
						out_q.sbox_word    <= {perm_rdata, word_q[23:0]};
						out_q.word_index   <= idx_q[7:2];
						out_q.last_word    <= (idx_q == 8'hFF);
						out_q.key_overflow <= ovf_q;
						out_valid_q        <= 1'b1;
						state_q            <= ST_OUT;
					end else begin
						idx_q   <= idx_q + 8'd1;
						state_q <= ST_EMIT_RD;
					end
				end
				ST_OUT: begin
					if (!sbox_stall) begin
						out_valid_q <= 1'b0;
						idx_q       <= idx_q + 8'd1;
						if (out_q.last_word) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sbox_valid = out_valid_q;
	assign sbox_data  = out_q;

	// A word on the output means the input side is held off.
	`RC4KS_ASSERT_NOW(a_out_blocks_in, clk, arst_n, sbox_valid, key_stall)
	// The key length never exceeds the store.
	`RC4KS_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(MAX_KEY_BYTES))
	// A final key byte always starts the schedule.
	`RC4KS_ASSERT_NEXT(a_last_starts, clk, arst_n, key_accept && key_data.key_last,
		key_stall && !sbox_valid)
	// Taking the final word returns the block to key intake with a clear count.
	`RC4KS_ASSERT_NEXT(a_last_word_done, clk, arst_n,
		sbox_valid && !sbox_stall && sbox_data.last_word,
		!key_stall && !sbox_valid && (count_q == '0))

endmodule

// ===== design/rc4ks_ram.sv =====
module rc4ks_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single write port; the registered read returns the old contents in the next cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== dv/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rc4ks_pkg::*;

	localparam int unsigned KEY_LIMIT    = 32;
	localparam int unsigned TARGET_BYTES = 160;
	localparam int unsigned IDLE_LIMIT   = 20000;
	localparam int unsigned DRAIN_CYCLES = 100;

	typedef logic [7:0] key_bytes_t [$];

	// Patterns the permutation receiver cycles through when applying backpressure.
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	// Predicts the permutation for every completed key and checks the words that come out.
	class perm_scoreboard;
		logic [7:0]  key_store [KEY_LIMIT];
		int unsigned key_count;
		bit          overflow_seen;
		sbox_out_t   expected_words [$];
		int unsigned mismatches;
		int unsigned words_checked;
		int unsigned keys_scheduled;
		int unsigned overflow_keys;

		// Records one accepted key byte; the final byte runs the key schedule.
		function void note_key_byte(key_in_t item);
			logic [7:0] perm [PERM_SIZE];
			logic [7:0] mix;
			logic [7:0] swap;
			sbox_out_t  word;

			if (key_count < KEY_LIMIT) begin
				key_store[key_count] = item.key_byte;
				key_count++;
			end else begin
				overflow_seen = 1'b1;
			end
			if (!item.key_last)
				return;

			// Identity fill, then the 256 mixing steps with a swap after each.
			for (int i = 0; i < PERM_SIZE; i++)
				perm[i] = i[7:0];
			mix = 8'h00;
			for (int i = 0; i < PERM_SIZE; i++) begin
				mix = mix + perm[i] + key_store[i % key_count];
				swap = perm[i];
				perm[i] = perm[mix];
				perm[mix] = swap;
			end

			// Pack four entries per word, lowest index in the low byte.
			for (int k = 0; k < WORD_COUNT; k++) begin
				word.sbox_word    = {perm[4*k+3], perm[4*k+2], perm[4*k+1], perm[4*k]};
				word.word_index   = k[5:0];
				word.last_word    = (k == WORD_COUNT - 1);
				word.key_overflow = overflow_seen;
				expected_words.push_back(word);
			end
			keys_scheduled++;
			if (overflow_seen)
				overflow_keys++;
			key_count = 0;
			overflow_seen = 1'b0;
		endfunction

		// Compares one received word with the oldest outstanding prediction.
		function void check_sbox_word(sbox_out_t got);
			sbox_out_t want;

			if (expected_words.size() == 0) begin
				$error("unexpected permutation word: index %0d, data %h",
					got.word_index, got.sbox_word);
				mismatches++;
				return;
			end
			want = expected_words.pop_front();
			words_checked++;
			if (got.sbox_word !== want.sbox_word) begin
				$error("sbox_word: expected %h, actual %h", want.sbox_word, got.sbox_word);
				mismatches++;
			end
			if (got.word_index !== want.word_index) begin
				$error("word_index: expected %0d, actual %0d", want.word_index, got.word_index);
				mismatches++;
			end
			if (got.last_word !== want.last_word) begin
				$error("last_word: expected %b, actual %b", want.last_word, got.last_word);
				mismatches++;
			end
			if (got.key_overflow !== want.key_overflow) begin
				$error("key_overflow: expected %b, actual %b",
					want.key_overflow, got.key_overflow);
				mismatches++;
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      key_valid = 1'b0;
	logic      key_stall;
	key_in_t   key_data = '0;
	logic      sbox_valid;
	logic      sbox_stall = 1'b0;
	sbox_out_t sbox_data;

	perm_scoreboard sb = new();

	int unsigned bytes_sent;
	int unsigned burst_left;
	bit          sender_gaps;
	int unsigned idle_cycles;
	stall_mode_t stall_mode = STALL_NONE;
	int unsigned stall_left;
	int unsigned stall_phase;

	rc4_key_schedule #(
		.MAX_KEY_BYTES(KEY_LIMIT)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_valid  (key_valid),
		.key_stall  (key_stall),
		.key_data   (key_data),
		.sbox_valid (sbox_valid),
		.sbox_stall (sbox_stall),
		.sbox_data  (sbox_data)
	);

	// Free-running clock with a 10 ns period.
	always #5 clk = ~clk;

	// Receiver backpressure: each pattern is held for a random span before a new one is chosen.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		stall_phase++;
		case (stall_mode)
			STALL_NONE:     sbox_stall <= 1'b0;
			STALL_LIGHT:    sbox_stall <= ($urandom_range(0, 3) == 0);
			STALL_PERIODIC: sbox_stall <= ((stall_phase % 5) < 2);
			default:        sbox_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	// Observe both channels at the rising edge and guard against a hung block.
	always @(posedge clk) begin
		if (arst_n) begin
			if (key_valid && !key_stall)
				sb.note_key_byte(key_data);
			if (sbox_valid && !sbox_stall)
				sb.check_sbox_word(sbox_data);
			if ((key_valid && !key_stall) || (sbox_valid && !sbox_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timed out after %0d cycles with no transaction.", IDLE_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Drops the key channel's valid for the given number of cycles.
	task automatic idle_sender(int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			key_valid <= 1'b0;
		end
	endtask

	// Presents one key byte and waits for the transaction, inserting gaps between bursts.
	task automatic send_key_byte(logic [7:0] value, bit last);
		if (burst_left == 0) begin
			if (sender_gaps)
				idle_sender($urandom_range(1, 8));
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		key_valid <= 1'b1;
		key_data  <= '{key_byte: value, key_last: last};
		do
			@(posedge clk);
		while (key_stall);
		bytes_sent++;
	endtask

	// Sends a whole key, flagging its final byte.
	task automatic send_key(key_bytes_t key);
		sender_gaps = ($urandom_range(0, 3) != 0);
		foreach (key[i])
			send_key_byte(key[i], i == key.size() - 1);
	endtask

	// Waits until every predicted word has been received.
	task automatic wait_for_drain();
		while (sb.expected_words.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		key_bytes_t  key;
		int unsigned key_len;
		int unsigned fill_style;
		int unsigned key_num;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed keys: single-byte extremes and short keys with edge values.
		send_key('{8'h00});
		send_key('{8'hFF});
		send_key('{8'h00, 8'hFF, 8'h80, 8'h01});
		send_key('{8'h55, 8'hAA, 8'h7F});
		send_key('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});

		// Hold off until the block has delivered everything predicted so far.
		idle_sender(1);
		wait_for_drain();

		// Random keys: first a full-length key and two overlong ones, then mostly short ones.
		key_num = 0;
		while (bytes_sent < TARGET_BYTES) begin
			if (key_num == 0)
				key_len = KEY_LIMIT;
			else if (key_num == 1)
				key_len = KEY_LIMIT + 1;
			else if (key_num == 2)
				key_len = KEY_LIMIT + 4;
			else if ($urandom_range(0, 9) < 7)
				key_len = $urandom_range(1, 8);
			else if ($urandom_range(0, 2) != 0)
				key_len = $urandom_range(9, KEY_LIMIT - 1);
			else
				key_len = $urandom_range(KEY_LIMIT, KEY_LIMIT + 8);
			fill_style = $urandom_range(0, 9);
			key.delete();
			repeat (key_len) begin
				if (fill_style == 0)
					key.push_back(8'h00);
				else if (fill_style == 1)
					key.push_back(8'hFF);
				else
					key.push_back(8'($urandom_range(0, 255)));
			end
			send_key(key);
			key_num++;
		end
		idle_sender(1);

		// Let the last permutation drain, then watch for stray words.
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d key bytes forming %0d keys, %0d of them with dropped bytes.",
			bytes_sent, sb.keys_scheduled, sb.overflow_keys);
		$display("Checked %0d permutation words under varied input gaps and output stalls.",
			sb.words_checked);
		if (sb.mismatches == 0 && sb.expected_words.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
